// ===== hw/rtl/dhlt_pkg.sv =====
package dhlt_pkg;

    localparam int ANG_W = 16;
    localparam int XY_W  = 33;
    localparam int Z_W   = 33;
    localparam int ZW_W  = 35;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic signed [ZW_W-1:0] PI_WIDE     = 35'sd3373259426;
    localparam logic signed [ZW_W-1:0] TWO_PI_WIDE = 35'sd6746518852;
    localparam logic signed [Z_W-1:0]  PI_Q30      = 33'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 33'sd1686629713;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic signed [19:0] ROT_MAX = 20'sd16384;
    localparam logic signed [19:0] ROT_MIN = -20'sd16384;
    localparam logic signed [19:0] POS_MAX = 20'sd32767;
    localparam logic signed [19:0] POS_MIN = -20'sd32768;

    typedef enum logic [2:0] {
        REG_JOINT_KIND    = 3'd0,
        REG_LINK_LENGTH   = 3'd1,
        REG_LINK_OFFSET_D = 3'd2,
        REG_COS_TWIST     = 3'd3,
        REG_SIN_TWIST     = 3'd4,
        REG_ZERO_OFFSET   = 3'd5,
        REG_FIXED_ANGLE   = 3'd6
    } t_reg_idx;

    typedef enum logic {
        JOINT_REVOLUTE  = 1'b0,
        JOINT_PRISMATIC = 1'b1
    } t_joint_kind;

    typedef struct packed {
        t_joint_kind              joint_kind;
        logic signed [ANG_W-1:0]  link_length;
        logic signed [ANG_W-1:0]  link_offset_d;
        logic signed [ANG_W-1:0]  cos_twist;
        logic signed [ANG_W-1:0]  sin_twist;
        logic signed [ANG_W-1:0]  zero_offset;
        logic signed [ANG_W-1:0]  fixed_angle;
    } t_cfg;

    typedef struct packed {
        logic signed [Z_W-1:0]    z;
        logic                     neg;
        logic signed [ANG_W-1:0]  pz;
    } t_qent;

    typedef struct packed {
        logic  push;
        t_qent wdata;
        logic  pop;
    } t_qctl;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 33'sd843314857;
            5'd1:    v = 33'sd497837829;
            5'd2:    v = 33'sd263043837;
            5'd3:    v = 33'sd133525159;
            5'd4:    v = 33'sd67021687;
            5'd5:    v = 33'sd33543516;
            5'd6:    v = 33'sd16775851;
            5'd7:    v = 33'sd8388437;
            5'd8:    v = 33'sd4194283;
            5'd9:    v = 33'sd2097149;
            5'd10:   v = 33'sd1048576;
            5'd11:   v = 33'sd524288;
            5'd12:   v = 33'sd262144;
            5'd13:   v = 33'sd131072;
            5'd14:   v = 33'sd65536;
            5'd15:   v = 33'sd32768;
            5'd16:   v = 33'sd16384;
            5'd17:   v = 33'sd8192;
            5'd18:   v = 33'sd4096;
            5'd19:   v = 33'sd2048;
            5'd20:   v = 33'sd1024;
            5'd21:   v = 33'sd512;
            5'd22:   v = 33'sd256;
            5'd23:   v = 33'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] sat_rot(input logic signed [19:0] v);
        logic signed [19:0] c;
        c = (v > ROT_MAX) ? ROT_MAX : ((v < ROT_MIN) ? ROT_MIN : v);
        return c[ANG_W-1:0];
    endfunction

    function automatic logic signed [ANG_W-1:0] sat_pos(input logic signed [19:0] v);
        logic signed [19:0] c;
        c = (v > POS_MAX) ? POS_MAX : ((v < POS_MIN) ? POS_MIN : v);
        return c[ANG_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/dhlt_queue.sv =====
module dhlt_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dhlt_pkg::t_qctl     i_ctl,
    output dhlt_pkg::t_qent     o_head,
    output logic                o_empty,
    output logic [dhlt_pkg::QCNT_W-1:0] o_count
);

    dhlt_pkg::t_qent r_mem [dhlt_pkg::QUEUE_DEPTH];
    logic [dhlt_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [dhlt_pkg::QCNT_W-1:0] r_count, n_count;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_head  = r_mem[r_rptr];
    assign do_pop  = i_ctl.pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (i_ctl.push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_ctl.push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_ctl.push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wptr] <= i_ctl.wdata;
        end
    end

endmodule

// ===== hw/rtl/dhlt_front.sv =====
module dhlt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dhlt_pkg::t_cfg                i_cfg,
    input  logic                          i_start,
    input  logic signed [15:0]            i_joint_value,
    input  logic [dhlt_pkg::QCNT_W-1:0]   i_q_count,
    output logic                          o_busy,
    output logic                          o_push,
    output dhlt_pkg::t_qent               o_wdata
);

    logic r1_v, r2_v;
    logic signed [15:0] r1_theta, r1_pz, r2_pz;
    logic signed [dhlt_pkg::Z_W-1:0] r2_z;

    logic signed [16:0] sum17;
    logic signed [15:0] sum_sat, n_theta, n_pz;
    logic signed [dhlt_pkg::ZW_W-1:0] z_wide, z_wrap;
    logic [dhlt_pkg::QCNT_W:0] used;
    logic accept;

    // words in flight ahead of the queue count against its free slots
    assign used   = {1'b0, i_q_count} + (dhlt_pkg::QCNT_W+1)'(r1_v)
                  + (dhlt_pkg::QCNT_W+1)'(r2_v);
    assign o_busy = (used >= (dhlt_pkg::QCNT_W+1)'(dhlt_pkg::QUEUE_DEPTH));
    assign accept = i_start && !o_busy;

    always_comb begin
        sum17 = 17'(i_joint_value) + 17'(i_cfg.zero_offset);
        if (sum17 > 17'sd32767) begin
            sum_sat = 16'sh7fff;
        end else if (sum17 < -17'sd32768) begin
            sum_sat = 16'sh8000;
        end else begin
            sum_sat = sum17[15:0];
        end
        if (i_cfg.joint_kind == dhlt_pkg::JOINT_PRISMATIC) begin
            n_theta = i_cfg.fixed_angle;
            n_pz    = sum_sat;
        end else begin
            n_theta = sum_sat;
            n_pz    = i_cfg.link_offset_d;
        end
    end

    // wrap into [-pi, pi]
    always_comb begin
        z_wide = {{(dhlt_pkg::ZW_W-34){r1_theta[15]}}, r1_theta, 18'b0};
        if (z_wide > dhlt_pkg::PI_WIDE) begin
            z_wrap = z_wide - dhlt_pkg::TWO_PI_WIDE;
        end else if (z_wide < -dhlt_pkg::PI_WIDE) begin
            z_wrap = z_wide + dhlt_pkg::TWO_PI_WIDE;
        end else begin
            z_wrap = z_wide;
        end
    end

    // fold into [-pi/2, pi/2]
    always_comb begin
        o_push   = r2_v;
        o_wdata.pz = r2_pz;
        if (r2_z > dhlt_pkg::HALF_PI_Q30) begin
            o_wdata.z   = r2_z - dhlt_pkg::PI_Q30;
            o_wdata.neg = 1'b1;
        end else if (r2_z < -dhlt_pkg::HALF_PI_Q30) begin
            o_wdata.z   = r2_z + dhlt_pkg::PI_Q30;
            o_wdata.neg = 1'b1;
        end else begin
            o_wdata.z   = r2_z;
            o_wdata.neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            r1_v <= accept;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_theta <= n_theta;
        r1_pz    <= n_pz;
        r2_z     <= z_wrap[dhlt_pkg::Z_W-1:0];
        r2_pz    <= r1_pz;
    end

endmodule

// ===== hw/rtl/dhlt_back.sv =====
module dhlt_back #(
    parameter int TRIG_STEPS = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dhlt_pkg::t_cfg      i_cfg,
    input  logic                i_q_empty,
    input  dhlt_pkg::t_qent     i_q_head,
    output logic                o_pop,
    output logic                o_valid,
    output logic signed [15:0]  o_rot_11,
    output logic signed [15:0]  o_rot_21,
    output logic signed [15:0]  o_rot_12,
    output logic signed [15:0]  o_rot_22,
    output logic signed [15:0]  o_rot_13,
    output logic signed [15:0]  o_rot_23,
    output logic signed [15:0]  o_pos_x,
    output logic signed [15:0]  o_pos_y,
    output logic signed [15:0]  o_pos_z
);

    localparam int XW = dhlt_pkg::XY_W;
    localparam int ZW = dhlt_pkg::Z_W;

    logic [TRIG_STEPS:0]      r_sv;
    logic signed [XW-1:0]     r_x   [TRIG_STEPS+1];
    logic signed [XW-1:0]     r_y   [TRIG_STEPS+1];
    logic signed [ZW-1:0]     r_z   [TRIG_STEPS+1];
    logic                     r_neg [TRIG_STEPS+1];
    logic signed [15:0]       r_pz  [TRIG_STEPS+1];

    logic                     r_tv, r_pv, r_ov;
    logic signed [15:0]       r_ct, r_st, r_pct, r_pst, r_tpz, r_ppz;
    logic signed [31:0]       r_p12, r_p22, r_p13, r_p23, r_px, r_py;

    logic signed [XW-1:0]     fx, fy;
    logic signed [XW:0]       rx, ry;
    logic signed [17:0]       cq, sq;

    assign o_pop   = !i_q_empty;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else begin
            r_sv[0] <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]   <= dhlt_pkg::CORDIC_GAIN;
        r_y[0]   <= '0;
        r_z[0]   <= i_q_head.z;
        r_neg[0] <= i_q_head.neg;
        r_pz[0]  <= i_q_head.pz;
    end

    for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_step
        logic signed [XW-1:0] n_x, n_y;
        logic signed [ZW-1:0] n_z, ang;

        assign ang = dhlt_pkg::atan_q30(5'(i));

        always_comb begin
            if (!r_z[i][ZW-1]) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - ang;
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[i+1] <= 1'b0;
            end else begin
                r_sv[i+1] <= r_sv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[i+1]   <= n_x;
            r_y[i+1]   <= n_y;
            r_z[i+1]   <= n_z;
            r_neg[i+1] <= r_neg[i];
            r_pz[i+1]  <= r_pz[i];
        end
    end

    // undo the half turn, round to q1.14 and clamp
    always_comb begin
        fx = r_neg[TRIG_STEPS] ? -r_x[TRIG_STEPS] : r_x[TRIG_STEPS];
        fy = r_neg[TRIG_STEPS] ? -r_y[TRIG_STEPS] : r_y[TRIG_STEPS];
        rx = (XW+1)'(fx) + (XW+1)'(32768);
        ry = (XW+1)'(fy) + (XW+1)'(32768);
        cq = 18'(rx >>> 16);
        sq = 18'(ry >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_tv <= r_sv[TRIG_STEPS];
            r_pv <= r_tv;
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ct  <= dhlt_pkg::sat_rot(20'(cq));
        r_st  <= dhlt_pkg::sat_rot(20'(sq));
        r_tpz <= r_pz[TRIG_STEPS];
    end

    always_ff @(posedge i_clk) begin
        r_p12 <= i_cfg.cos_twist * r_st;
        r_p22 <= i_cfg.cos_twist * r_ct;
        r_p13 <= i_cfg.sin_twist * r_st;
        r_p23 <= i_cfg.sin_twist * r_ct;
        r_px  <= i_cfg.link_length * r_ct;
        r_py  <= i_cfg.link_length * r_st;
        r_pct <= r_ct;
        r_pst <= r_st;
        r_ppz <= r_tpz;
    end

    function automatic logic signed [19:0] rnd14(input logic signed [31:0] p);
        logic signed [32:0] s;
        s = 33'(p) + 33'sd8192;
        return 20'(s >>> 14);
    endfunction

    always_ff @(posedge i_clk) begin
        o_rot_11 <= r_pct;
        o_rot_21 <= r_pst;
        o_rot_12 <= dhlt_pkg::sat_rot(-rnd14(r_p12));
        o_rot_22 <= dhlt_pkg::sat_rot(rnd14(r_p22));
        o_rot_13 <= dhlt_pkg::sat_rot(rnd14(r_p13));
        o_rot_23 <= dhlt_pkg::sat_rot(-rnd14(r_p23));
        o_pos_x  <= dhlt_pkg::sat_pos(rnd14(r_px));
        o_pos_y  <= dhlt_pkg::sat_pos(rnd14(r_py));
        o_pos_z  <= r_ppz;
    end

endmodule

// ===== hw/rtl/dh_link_transform.sv =====
// One Denavit-Hartenberg link per joint word: a word is taken at each clock edge with i_start
// high and o_busy low, one word per cycle sustained, and its rotation and position appear
// on the o_ ports for a single cycle with o_valid high, in order. A word passes through the
// offset sum register, the angle wrap, the queue, the CORDIC pipeline, one stage per step,
// rounding, the product stage and the output register. Results cannot be held off, so they
// must be captured in the o_valid cycle; o_busy rises only if the queue count plus the words
// in flight ahead of it reaches the queue depth, which never happens in normal operation.
// Configuration goes through i_cfg_we/i_cfg_idx/i_cfg_data and must only be written while
// no word is in flight; writes to unknown indexes are dropped.
module dh_link_transform #(
    parameter int TRIG_STEPS = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_start,
    output logic                o_busy,
    input  logic signed [15:0]  i_joint_value,
    output logic                o_valid,
    output logic signed [15:0]  o_rot_11,
    output logic signed [15:0]  o_rot_21,
    output logic signed [15:0]  o_rot_12,
    output logic signed [15:0]  o_rot_22,
    output logic signed [15:0]  o_rot_13,
    output logic signed [15:0]  o_rot_23,
    output logic signed [15:0]  o_pos_x,
    output logic signed [15:0]  o_pos_y,
    output logic signed [15:0]  o_pos_z
);

    dhlt_pkg::t_cfg   r_cfg;
    dhlt_pkg::t_qctl  qctl;
    dhlt_pkg::t_qent  q_head;
    logic             q_empty;
    logic [dhlt_pkg::QCNT_W-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.joint_kind    <= dhlt_pkg::JOINT_REVOLUTE;
            r_cfg.link_length   <= '0;
            r_cfg.link_offset_d <= '0;
            r_cfg.cos_twist     <= 16'sd16384;
            r_cfg.sin_twist     <= '0;
            r_cfg.zero_offset   <= '0;
            r_cfg.fixed_angle   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dhlt_pkg::REG_JOINT_KIND:    r_cfg.joint_kind <= dhlt_pkg::t_joint_kind'(i_cfg_data[0]);
                dhlt_pkg::REG_LINK_LENGTH:   r_cfg.link_length   <= i_cfg_data;
                dhlt_pkg::REG_LINK_OFFSET_D: r_cfg.link_offset_d <= i_cfg_data;
                dhlt_pkg::REG_COS_TWIST:     r_cfg.cos_twist     <= i_cfg_data;
                dhlt_pkg::REG_SIN_TWIST:     r_cfg.sin_twist     <= i_cfg_data;
                dhlt_pkg::REG_ZERO_OFFSET:   r_cfg.zero_offset   <= i_cfg_data;
                dhlt_pkg::REG_FIXED_ANGLE:   r_cfg.fixed_angle   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dhlt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_start       (i_start),
        .i_joint_value (i_joint_value),
        .i_q_count     (q_count),
        .o_busy        (o_busy),
        .o_push        (qctl.push),
        .o_wdata       (qctl.wdata)
    );

    dhlt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    dhlt_back #(
        .TRIG_STEPS (TRIG_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_pop     (qctl.pop),
        .o_valid   (o_valid),
        .o_rot_11  (o_rot_11),
        .o_rot_21  (o_rot_21),
        .o_rot_12  (o_rot_12),
        .o_rot_22  (o_rot_22),
        .o_rot_13  (o_rot_13),
        .o_rot_23  (o_rot_23),
        .o_pos_x   (o_pos_x),
        .o_pos_y   (o_pos_y),
        .o_pos_z   (o_pos_z)
    );

endmodule

// ===== test/tb_top.sv =====
module tb_top;

    localparam int TRIG_STEPS = 14;
    localparam int LATENCY = TRIG_STEPS + 6;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam longint PI_Z = 64'sd3373259426;
    localparam longint HALF_PI_Z = 64'sd1686629713;
    localparam longint GAIN_X0 = 64'sd652032874;

    localparam int F_ROT_11 = 0;
    localparam int F_ROT_21 = 1;
    localparam int F_ROT_12 = 2;
    localparam int F_ROT_22 = 3;
    localparam int F_ROT_13 = 4;
    localparam int F_ROT_23 = 5;
    localparam int F_POS_X = 6;
    localparam int F_POS_Y = 7;
    localparam int F_POS_Z = 8;

    typedef logic [8:0][15:0] t_link_frame;

    typedef struct {
        int                 cfg_sel;
        logic signed [15:0] joint;
        logic [8:0]         pinned;
        t_link_frame        typed;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_start = 1'b0;
    logic signed [15:0] i_joint_value = '0;
    logic               o_busy;
    logic               o_valid;
    logic signed [15:0] o_rot_11, o_rot_21, o_rot_12, o_rot_22, o_rot_13, o_rot_23;
    logic signed [15:0] o_pos_x, o_pos_y, o_pos_z;

    t_link_frame     pending_frames[$];
    t_dir_row        dir_rows[$];
    dhlt_pkg::t_cfg  dir_cfg[6];
    dhlt_pkg::t_cfg  link_cfg;
    int              mismatch_count = 0;
    t_link_frame     got_frame, want_frame;

    longint atan_z[24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128
    };

    string field_name[9] = '{
        "rot_11", "rot_21", "rot_12", "rot_22", "rot_13", "rot_23",
        "pos_x", "pos_y", "pos_z"
    };

    dh_link_transform #(
        .TRIG_STEPS(TRIG_STEPS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_start(i_start),
        .o_busy(o_busy),
        .i_joint_value(i_joint_value),
        .o_valid(o_valid),
        .o_rot_11(o_rot_11),
        .o_rot_21(o_rot_21),
        .o_rot_12(o_rot_12),
        .o_rot_22(o_rot_22),
        .o_rot_13(o_rot_13),
        .o_rot_23(o_rot_23),
        .o_pos_x(o_pos_x),
        .o_pos_y(o_pos_y),
        .o_pos_z(o_pos_z)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round14(longint a, longint b);
        return (a * b + 8192) >>> 14;
    endfunction

    function automatic void cordic_trig(input longint theta, output longint c14,
                                        output longint s14);
        longint z, x, y, nx;
        bit     flip;
        z = theta * 262144;
        x = GAIN_X0;
        y = 0;
        flip = 1'b0;
        if (z > PI_Z) z = z - 2 * PI_Z;
        if (z < -PI_Z) z = z + 2 * PI_Z;
        if (z > HALF_PI_Z) begin
            z = z - PI_Z;
            flip = 1'b1;
        end else if (z < -HALF_PI_Z) begin
            z = z + PI_Z;
            flip = 1'b1;
        end
        for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_z[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_z[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c14 = clamp_to((x + 32768) >>> 16, -16384, 16384);
        s14 = clamp_to((y + 32768) >>> 16, -16384, 16384);
    endfunction

    function automatic t_link_frame predict_link(dhlt_pkg::t_cfg c, logic signed [15:0] joint);
        longint      sum, theta, pz, ct, st, v;
        t_link_frame f;
        sum = clamp_to(longint'(joint) + longint'(c.zero_offset), -32768, 32767);
        if (c.joint_kind == dhlt_pkg::JOINT_REVOLUTE) begin
            theta = sum;
            pz = c.link_offset_d;
        end else begin
            theta = c.fixed_angle;
            pz = sum;
        end
        cordic_trig(theta, ct, st);
        f[F_ROT_11] = ct[15:0];
        f[F_ROT_21] = st[15:0];
        v = clamp_to(-round14(c.cos_twist, st), -16384, 16384);
        f[F_ROT_12] = v[15:0];
        v = clamp_to(round14(c.cos_twist, ct), -16384, 16384);
        f[F_ROT_22] = v[15:0];
        v = clamp_to(round14(c.sin_twist, st), -16384, 16384);
        f[F_ROT_13] = v[15:0];
        v = clamp_to(-round14(c.sin_twist, ct), -16384, 16384);
        f[F_ROT_23] = v[15:0];
        v = clamp_to(round14(c.link_length, ct), -32768, 32767);
        f[F_POS_X] = v[15:0];
        v = clamp_to(round14(c.link_length, st), -32768, 32767);
        f[F_POS_Y] = v[15:0];
        f[F_POS_Z] = pz[15:0];
        return f;
    endfunction

    function automatic t_dir_row mk_row(int sel, logic signed [15:0] joint, logic [8:0] pin,
                                        logic signed [15:0] pz, logic signed [15:0] r22,
                                        logic signed [15:0] r23);
        t_dir_row r;
        r.cfg_sel = sel;
        r.joint = joint;
        r.pinned = pin;
        r.typed = '0;
        r.typed[F_POS_Z] = pz;
        r.typed[F_ROT_22] = r22;
        r.typed[F_ROT_23] = r23;
        return r;
    endfunction

    function automatic dhlt_pkg::t_cfg random_link_cfg();
        dhlt_pkg::t_cfg c;
        c.joint_kind = dhlt_pkg::t_joint_kind'($urandom_range(1));
        c.link_length = 16'($urandom);
        c.link_offset_d = 16'($urandom);
        if ($urandom_range(99) < 85) begin
            c.cos_twist = 16'($urandom_range(32768) - 16384);
            c.sin_twist = 16'($urandom_range(32768) - 16384);
        end else begin
            c.cos_twist = 16'($urandom);
            c.sin_twist = 16'($urandom);
        end
        if ($urandom_range(1) == 0) c.zero_offset = 16'($urandom_range(4096) - 2048);
        else c.zero_offset = 16'($urandom);
        c.fixed_angle = 16'($urandom);
        return c;
    endfunction

    function automatic logic signed [15:0] random_joint(dhlt_pkg::t_cfg c);
        int sel, t;
        int marks[7] = '{12868, -12868, 6434, -6434, 25736, -25736, 0};
        sel = $urandom_range(99);
        if (sel < 55) return 16'($urandom);
        if (sel < 70) begin
            case ($urandom_range(4))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return 16'sh0000;
                3: return 16'shffff;
                default: return 16'sh0001;
            endcase
        end
        t = marks[$urandom_range(6)] + int'($urandom_range(8)) - 4;
        if (c.joint_kind == dhlt_pkg::JOINT_REVOLUTE) t = t - int'(c.zero_offset);
        return 16'(t);
    endfunction

    task automatic hold_until_drained();
        i_start <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_link_cfg(dhlt_pkg::t_cfg c);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= dhlt_pkg::REG_JOINT_KIND;
        i_cfg_data <= {15'($urandom), c.joint_kind};
        @(posedge i_clk);
        i_cfg_idx <= dhlt_pkg::REG_LINK_LENGTH;
        i_cfg_data <= c.link_length;
        @(posedge i_clk);
        i_cfg_idx <= dhlt_pkg::REG_LINK_OFFSET_D;
        i_cfg_data <= c.link_offset_d;
        @(posedge i_clk);
        i_cfg_idx <= dhlt_pkg::REG_COS_TWIST;
        i_cfg_data <= c.cos_twist;
        @(posedge i_clk);
        i_cfg_idx <= dhlt_pkg::REG_SIN_TWIST;
        i_cfg_data <= c.sin_twist;
        @(posedge i_clk);
        i_cfg_idx <= dhlt_pkg::REG_ZERO_OFFSET;
        i_cfg_data <= c.zero_offset;
        @(posedge i_clk);
        i_cfg_idx <= dhlt_pkg::REG_FIXED_ANGLE;
        i_cfg_data <= c.fixed_angle;
        @(posedge i_clk);
        // dropped by the block
        i_cfg_idx <= REG_UNUSED;
        i_cfg_data <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        link_cfg = c;
    endtask

    task automatic push_joint_word(logic signed [15:0] joint, int idle_pct, logic [8:0] pin,
                                   t_link_frame typed);
        int          gap;
        t_link_frame want;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_joint_value <= joint;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        want = predict_link(link_cfg, joint);
        for (int i = 0; i < 9; i++) begin
            if (pin[i]) want[i] = typed[i];
        end
        pending_frames.push_back(want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            got_frame = {o_pos_z, o_pos_y, o_pos_x, o_rot_23, o_rot_13, o_rot_22,
                         o_rot_12, o_rot_21, o_rot_11};
            if (o_valid !== 1'b1) begin
                $error("o_valid unknown");
                mismatch_count++;
            end else if (pending_frames.size() == 0) begin
                $error("unexpected word on output");
                mismatch_count++;
            end else begin
                want_frame = pending_frames.pop_front();
                for (int i = 0; i < 9; i++) begin
                    if (got_frame[i] !== want_frame[i]) begin
                        $error("%s expected %0d actual %0d", field_name[i],
                               $signed(want_frame[i]), $signed(got_frame[i]));
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        int             cur_sel;
        int             pct;
        dhlt_pkg::t_cfg c;
        dir_cfg[0] = '{dhlt_pkg::JOINT_REVOLUTE, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                       16'sd0, 16'sd0};
        dir_cfg[1] = '{dhlt_pkg::JOINT_PRISMATIC, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                       16'sd32767, 16'sd0};
        dir_cfg[2] = '{dhlt_pkg::JOINT_PRISMATIC, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                       -16'sd32768, 16'sd32767};
        dir_cfg[3] = '{dhlt_pkg::JOINT_REVOLUTE, 16'sd32767, -16'sd32768, 16'sd32767,
                       -16'sd32768, 16'sd0, -16'sd32768};
        dir_cfg[4] = '{dhlt_pkg::JOINT_REVOLUTE, -16'sd32768, 16'sd32767, -16'sd16384,
                       16'sd16384, 16'sd32767, 16'sd0};
        dir_cfg[5] = '{dhlt_pkg::JOINT_REVOLUTE, 16'sd16384, 16'sd0, 16'sd11585, 16'sd11585,
                       16'sd0, 16'sd0};
        link_cfg = dir_cfg[0];

        // after reset: no length, no offset, no sine of twist
        dir_rows.push_back(mk_row(0, 16'sd0, 9'b111110000, 16'sd0, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(0, -16'sd32768, 9'b111110000, 16'sd0, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(0, 16'sd32767, 9'b111110000, 16'sd0, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(0, 16'sd12868, 9'b111110000, 16'sd0, 16'sd0, 16'sd0));
        // prismatic, z sum saturating high
        dir_rows.push_back(mk_row(1, 16'sd32767, 9'b111111100, 16'sd32767, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(1, -16'sd32768, 9'b111111100, -16'sd1, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(1, 16'sd0, 9'b111111100, 16'sd32767, 16'sd0, 16'sd0));
        // prismatic, z sum saturating low, extreme fixed angle
        dir_rows.push_back(mk_row(2, -16'sd32768, 9'b111111100, -16'sd32768, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(2, 16'sd32767, 9'b111111100, -16'sd1, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(2, 16'sd1, 9'b111111100, -16'sd32767, 16'sd0, 16'sd0));
        // twist out of range, products clamp
        dir_rows.push_back(mk_row(3, 16'sd0, 9'b100101000, -16'sd32768, 16'sd16384,
                                  16'sd16384));
        dir_rows.push_back(mk_row(3, 16'sd100, 9'b100101000, -16'sd32768, 16'sd16384,
                                  16'sd16384));
        dir_rows.push_back(mk_row(3, -16'sd100, 9'b100101000, -16'sd32768, 16'sd16384,
                                  16'sd16384));
        dir_rows.push_back(mk_row(3, 16'sd12868, 9'b100000000, -16'sd32768, 16'sd0, 16'sd0));
        // revolute, angle sum saturating
        dir_rows.push_back(mk_row(4, 16'sd32767, 9'b100000000, 16'sd32767, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(4, -16'sd32768, 9'b100000000, 16'sd32767, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(4, -16'sd1, 9'b100000000, 16'sd32767, 16'sd0, 16'sd0));
        // quarter and half turns, wrap of a full turn
        dir_rows.push_back(mk_row(5, 16'sd6434, 9'b100000000, 16'sd0, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(5, -16'sd6434, 9'b100000000, 16'sd0, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(5, 16'sd12868, 9'b100000000, 16'sd0, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(5, -16'sd12867, 9'b100000000, 16'sd0, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(5, 16'sd25736, 9'b100000000, 16'sd0, 16'sd0, 16'sd0));
        dir_rows.push_back(mk_row(5, -16'sd25736, 9'b100000000, 16'sd0, 16'sd0, 16'sd0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_sel = 0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].cfg_sel != cur_sel) begin
                hold_until_drained();
                write_link_cfg(dir_cfg[dir_rows[k].cfg_sel]);
                cur_sel = dir_rows[k].cfg_sel;
            end
            push_joint_word(dir_rows[k].joint, 11, dir_rows[k].pinned, dir_rows[k].typed);
        end

        for (int ph = 0; ph < 13; ph++) begin
            if (ph == 0) begin
                c = '{dhlt_pkg::JOINT_PRISMATIC, 16'sd32767, 16'sd32767, 16'sd32767,
                      16'sd32767, 16'sd32767, 16'sd32767};
            end else if (ph == 1) begin
                c = '{dhlt_pkg::JOINT_REVOLUTE, -16'sd32768, -16'sd32768, -16'sd32768,
                      -16'sd32768, -16'sd32768, -16'sd32768};
            end else begin
                c = random_link_cfg();
            end
            pct = (ph < 5) ? 11 : ((ph < 10) ? 53 : 0);
            hold_until_drained();
            write_link_cfg(c);
            for (int n = 0; n < 50; n++) begin
                push_joint_word(random_joint(link_cfg), pct, 9'b0, '0);
            end
        end

        hold_until_drained();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("dh_link_transform regression: pass");
        end else begin
            $display("dh_link_transform regression: fail");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("dh_link_transform regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dhlt_pkg.sv
hw/rtl/dhlt_queue.sv
hw/rtl/dhlt_front.sv
hw/rtl/dhlt_back.sv
hw/rtl/dh_link_transform.sv
test/tb_top.sv
